// File: hdl/plic_pkg.sv
// ----------------------------------------------------------------------------
// plic_pkg
// Shared constants for the per-channel linear interpolation correction block.
// ----------------------------------------------------------------------------
package plic_pkg;

	localparam int NUM_CHANNELS_DEF    = 256;
	localparam int NUM_BREAKPOINTS_DEF = 6;

	// breakpoint registers on the APB port
	localparam int NUM_REGS   = 6;
	localparam int REG_IW     = 3;
	localparam int PADDR_W    = 5;
	localparam int PDATA_W    = 32;

	// payload widths
	localparam int WORD_W     = 32;
	localparam int CHAN_W     = 8;
	localparam int SLOT_W     = 3;
	localparam int STATUS_W   = 2;

	// s_tdata layout: channel, slot, word_value, position, zero fill
	localparam int CHAN_LSB   = 0;
	localparam int SLOT_LSB   = CHAN_LSB + CHAN_W;
	localparam int WORD_LSB   = SLOT_LSB + SLOT_W;
	localparam int POS_LSB    = WORD_LSB + WORD_W;
	localparam int S_FIELDS_W = POS_LSB + WORD_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

	// cmd codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_LOADED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_SEGMENT = 2'd2;

endpackage

// File: hdl/per_channel_linear_interp_correction.sv
// ----------------------------------------------------------------------------
// per_channel_linear_interp_correction
// Per-channel piecewise linear correction, clamped at both ends, Q15.16.
// ----------------------------------------------------------------------------
// Channel   Dir  Transfer                 Payload
// s_axis    in   s_tvalid & s_tready      s_tuser cmd; s_tdata channel/slot/word/position
// m_axis    out  m_tvalid & m_tready      m_tuser status; m_tdata correction
// apb       in   psel&penable&pwrite      breakpoint_0..5 at 4*i
//
// A write or an unloaded query goes from decode to output; its result can first transfer
// at the same edge as the earliest next input transfer. An interpolating query runs decode,
// a search over up to 5 segments, two table reads, a 32x32 partial product and add, the
// shared restoring divider over the 64-bit product, then a final add. Clamped queries
// read an end word; zero-width segments give the left word. s_tready is high only while
// the sequencer is idle; a result may still wait then. No clearing after reset.
// ----------------------------------------------------------------------------
module per_channel_linear_interp_correction #(
	parameter int NUM_CHANNELS    = plic_pkg::NUM_CHANNELS_DEF,
	parameter int NUM_BREAKPOINTS = plic_pkg::NUM_BREAKPOINTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// APB configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [plic_pkg::PADDR_W-1:0]      paddr,
	input  logic [plic_pkg::PDATA_W-1:0]      pwdata,
	output logic [plic_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// channel[7:0], slot[10:8], word_value[42:11], position[74:43], zero[79:75]
	input  logic [plic_pkg::S_TDATA_W-1:0]    s_tdata,
	input  logic                              s_tuser,   // cmd[0]
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [plic_pkg::WORD_W-1:0]       m_tdata,   // correction[31:0]
	output logic [plic_pkg::STATUS_W-1:0]     m_tuser    // status[1:0]
);
	import plic_pkg::*;

	localparam int LD_DEPTH  = (NUM_CHANNELS < 256) ? NUM_CHANNELS : 256;
	localparam int LD_IW     = (LD_DEPTH > 1) ? $clog2(LD_DEPTH) : 1;
	localparam int TBL_DEPTH = LD_DEPTH * NUM_BREAKPOINTS;
	localparam int ADDR_W    = $clog2(TBL_DEPTH);
	localparam int SEG_W     = $clog2(NUM_BREAKPOINTS);
	localparam int DIV_N     = 2 * WORD_W;
	localparam int CNT_W     = $clog2(DIV_N);
	localparam logic [SEG_W-1:0]  LAST_SEG = SEG_W'(NUM_BREAKPOINTS - 1);
	localparam logic [CNT_W-1:0]  LAST_CNT = CNT_W'(DIV_N - 1);
	localparam logic [REG_IW-1:0] LAST_BP  = REG_IW'(NUM_BREAKPOINTS - 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_CLAMP  = 4'd2;
	localparam logic [3:0] S_SEARCH = 4'd3;
	localparam logic [3:0] S_READL  = 4'd4;
	localparam logic [3:0] S_READR  = 4'd5;
	localparam logic [3:0] S_MUL    = 4'd6;
	localparam logic [3:0] S_ADD    = 4'd7;
	localparam logic [3:0] S_DIV    = 4'd8;
	localparam logic [3:0] S_FIN    = 4'd9;
	localparam logic [3:0] S_OUT    = 4'd10;

	// control state
	logic [3:0]          state_q;
	logic [SEG_W-1:0]    seg_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                m_tvalid_q;
	logic [LD_DEPTH-1:0] loaded_q;
	logic signed [WORD_W-1:0] bp_q [NUM_REGS];

	// payload registers
	logic                       cmd_q;
	logic [CHAN_W-1:0]          ch_q;
	logic [SLOT_W-1:0]          slot_q;
	logic [WORD_W-1:0]          word_q;
	logic signed [WORD_W-1:0]   pos_q;
	logic [WORD_W-1:0]          w_q;
	logic [WORD_W-1:0]          dy_q;
	logic                       wzero_q;
	logic [WORD_W-1:0]          left_q;
	logic [WORD_W:0]            mag_q;
	logic                       neg_q;
	logic [DIV_N-1:0]           prod_s1;
	logic [DIV_N-1:0]           quo_q;
	logic [WORD_W-1:0]          rem_q;
	logic [WORD_W-1:0]          res_corr_q;
	logic [STATUS_W-1:0]        res_status_q;
	logic [WORD_W-1:0]          m_corr_q;
	logic [STATUS_W-1:0]        m_status_q;

	// table memory
	logic [WORD_W-1:0] tbl_mem [TBL_DEPTH];
	logic [WORD_W-1:0] rd_data_q;
	logic [ADDR_W-1:0] base_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic [SEG_W-1:0]  rd_slot;
	logic              tbl_we;

	logic              ch_ok;
	logic              slot_ok;
	logic              is_loaded;
	logic              below;
	logic              above;
	logic signed [WORD_W-1:0] seg_lo;
	logic signed [WORD_W-1:0] seg_hi;
	logic              seg_hit;
	logic [WORD_W:0]   d_diff;
	logic [WORD_W:0]   rem_shift;
	logic              rem_ge;
	logic              out_free;
	logic              cfg_we;
	logic [REG_IW-1:0] cfg_idx;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[REG_IW+1:2];
	assign cfg_we  = psel & penable & pwrite & pready;
	assign prdata  = (cfg_idx < REG_IW'(NUM_REGS)) ? bp_q[cfg_idx] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				bp_q[i] <= '0;
			end
		end else if (cfg_we && cfg_idx < REG_IW'(NUM_REGS)) begin
			bp_q[cfg_idx] <= pwdata;
		end
	end

	// ---------------- decode helpers ----------------
	assign ch_ok     = 13'(ch_q) < 13'(NUM_CHANNELS);
	assign slot_ok   = slot_q < SLOT_W'(NUM_BREAKPOINTS);
	assign is_loaded = ch_ok && loaded_q[ch_q[LD_IW-1:0]];
	assign below     = pos_q < bp_q[0];
	assign above     = pos_q > bp_q[LAST_BP];
	assign seg_lo    = bp_q[REG_IW'(seg_q - SEG_W'(1))];
	assign seg_hi    = bp_q[REG_IW'(seg_q)];
	assign seg_hit   = (seg_lo <= pos_q) && (seg_hi >= pos_q);
	assign d_diff    = {rd_data_q[WORD_W-1], rd_data_q} - {left_q[WORD_W-1], left_q};
	assign out_free  = !m_tvalid_q || m_tready;

	// shared divider step: shift in the next dividend bit, trial subtract
	assign rem_shift = {rem_q, quo_q[DIV_N-1]};
	assign rem_ge    = rem_shift >= {1'b0, w_q};

	// ---------------- table addressing ----------------
	assign base_addr = ADDR_W'(ch_q[LD_IW-1:0]) * ADDR_W'(NUM_BREAKPOINTS);
	assign wr_addr   = base_addr + ADDR_W'(slot_q);
	assign rd_addr   = base_addr + ADDR_W'(rd_slot);
	assign tbl_we    = (state_q == S_DECODE) && (cmd_q == CMD_WRITE) && ch_ok && slot_ok;

	always_comb begin
		unique case (state_q)
			S_DECODE: rd_slot = below ? '0 : LAST_SEG;
			S_SEARCH: rd_slot = seg_q - SEG_W'(1);
			S_READL:  rd_slot = seg_q;
			default:  rd_slot = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[wr_addr] <= word_q;
		end
		rd_data_q <= tbl_mem[rd_addr];
	end

	// ---------------- sequencer ----------------
	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			seg_q      <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			loaded_q   <= '0;
		end else begin
			// load a new result, else drop the one just taken
			if (state_q == S_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					seg_q <= SEG_W'(1);
					if (cmd_q == CMD_WRITE) begin
						if (tbl_we) begin
							loaded_q[ch_q[LD_IW-1:0]] <= 1'b1;
						end
						state_q <= S_OUT;
					end else if (!is_loaded) begin
						state_q <= S_OUT;
					end else if (below || above) begin
						state_q <= S_CLAMP;
					end else begin
						state_q <= S_SEARCH;
					end
				end
				S_CLAMP: state_q <= S_OUT;
				S_SEARCH: begin
					if (seg_hit) begin
						state_q <= S_READL;
					end else if (seg_q == LAST_SEG) begin
						state_q <= S_OUT;
					end else begin
						seg_q <= seg_q + SEG_W'(1);
					end
				end
				S_READL: state_q <= S_READR;
				S_READR: state_q <= wzero_q ? S_OUT : S_MUL;
				S_MUL:   state_q <= S_ADD;
				S_ADD: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == LAST_CNT) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		prod_s1 <= DIV_N'(mag_q[WORD_W-1:0]) * DIV_N'(dy_q);
		unique case (state_q)
			S_IDLE: begin
				cmd_q  <= s_tuser;
				ch_q   <= s_tdata[CHAN_LSB +: CHAN_W];
				slot_q <= s_tdata[SLOT_LSB +: SLOT_W];
				word_q <= s_tdata[WORD_LSB +: WORD_W];
				pos_q  <= s_tdata[POS_LSB +: WORD_W];
			end
			S_DECODE: begin
				res_corr_q   <= '0;
				res_status_q <= (cmd_q == CMD_QUERY && !is_loaded) ? ST_NOT_LOADED : ST_OK;
			end
			S_CLAMP: res_corr_q <= rd_data_q;
			S_SEARCH: begin
				// hi >= lo on a hit, so both differences fit unsigned 32 bits
				w_q     <= WORD_W'(seg_hi - seg_lo);
				dy_q    <= WORD_W'(pos_q - seg_lo);
				wzero_q <= (seg_hi == seg_lo);
				if (!seg_hit && seg_q == LAST_SEG) begin
					res_status_q <= ST_NO_SEGMENT;
				end
			end
			S_READL: left_q <= rd_data_q;
			S_READR: begin
				neg_q      <= d_diff[WORD_W];
				mag_q      <= d_diff[WORD_W] ? -d_diff : d_diff;
				res_corr_q <= left_q;
			end
			S_ADD: begin
				// top bit of |d| is never set, since |d| is at most 2^32-1
				quo_q <= prod_s1 + (mag_q[WORD_W] ? {dy_q, WORD_W'(0)} : DIV_N'(0));
				rem_q <= '0;
			end
			S_DIV: begin
				quo_q <= {quo_q[DIV_N-2:0], rem_ge};
				rem_q <= rem_ge ? WORD_W'(rem_shift - {1'b0, w_q}) : rem_shift[WORD_W-1:0];
			end
			S_FIN: begin
				res_corr_q <= left_q + (neg_q ? -quo_q[WORD_W-1:0] : quo_q[WORD_W-1:0]);
			end
			S_OUT: begin
				if (out_free) begin
					m_corr_q   <= res_corr_q;
					m_status_q <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_corr_q;
	assign m_tuser  = m_status_q;

`ifndef SYNTH
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
		else $error("error result carries a nonzero correction");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == S_DECODE)
		else $error("accepted item did not enter decode");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && cnt_q == LAST_CNT |=> state_q == S_FIN)
		else $error("divider did not finish after its last step");

	a_write_marks: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |=> loaded_q[$past(ch_q[LD_IW-1:0])])
		else $error("table write did not mark its channel loaded");
`endif

endmodule

// File: test/tb_per_channel_linear_interp_correction.sv
// ----------------------------------------------------------------------------
// tb_per_channel_linear_interp_correction
// Self-checking bench for the per-channel clamped linear correction block.
// Loads channel tables and queries positions over the input stream. Uses the
// reset breakpoints, then writes sets over APB while the block is idle:
// narrow, full span, repeated, unsorted, descending and wide. Each result is
// compared with a bit-exact Q15.16 predictor. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_per_channel_linear_interp_correction;
	timeunit 1ns;
	timeprecision 1ps;
	import plic_pkg::*;

	localparam int NCH          = NUM_CHANNELS_DEF;
	localparam int NBP          = NUM_BREAKPOINTS_DEF;
	localparam int PHASE_ITEMS  = 242;
	localparam int DRAIN_CYCLES = 120;
	localparam int CYCLE_LIMIT  = 900_000;
	localparam logic [5:0] ALL_SLOTS = 6'h3f;

	typedef struct packed {
		logic [WORD_W-1:0]   correction;
		logic [STATUS_W-1:0] status;
	} corr_result_t;

	typedef enum {BP_NARROW, BP_FULL_SPAN, BP_REPEATED, BP_UNSORTED, BP_DESCENDING,
		BP_WIDE} bp_shape_t;

	class interp_scoreboard;
		logic [WORD_W-1:0]        table_words [NCH*NBP];
		bit                       loaded [NCH];
		logic signed [WORD_W-1:0] breakpoints [NUM_REGS];
		corr_result_t             expected_results [$];
		int errors, n_writes, n_queries, n_interp, n_clamped, n_zero_width;
		int n_unloaded, n_no_segment;

		function new();
			foreach (loaded[i]) loaded[i] = 1'b0;
			foreach (breakpoints[i]) breakpoints[i] = '0;
			foreach (table_words[i]) table_words[i] = '0;
		endfunction

		function void set_breakpoint(int idx, logic [WORD_W-1:0] val);
			if (idx < NUM_REGS) breakpoints[idx] = val;
		endfunction

		function corr_result_t interpolate_correction(int unsigned ch, logic signed [31:0] pos);
			longint y, lo, hi, left, right, d, dy, w;
			logic [63:0] mag, prod, q;
			corr_result_t r;
			int base;
			r.correction = '0;
			r.status = ST_OK;
			if (ch >= NCH || !loaded[ch]) begin
				n_unloaded++;
				r.status = ST_NOT_LOADED;
				return r;
			end
			base = ch * NBP;
			y = longint'(pos);
			if (y < longint'(breakpoints[0])) begin
				n_clamped++;
				r.correction = table_words[base];
				return r;
			end
			if (y > longint'(breakpoints[NBP-1])) begin
				n_clamped++;
				r.correction = table_words[base+NBP-1];
				return r;
			end
			// first segment holding the position wins
			for (int i = 1; i < NBP; i++) begin
				lo = longint'(breakpoints[i-1]);
				hi = longint'(breakpoints[i]);
				if (lo <= y && hi >= y) begin
					left  = longint'(signed'(table_words[base+i-1]));
					right = longint'(signed'(table_words[base+i]));
					w = hi - lo;
					if (w == 0) begin
						n_zero_width++;
						r.correction = table_words[base+i-1];
						return r;
					end
					n_interp++;
					d = right - left;
					dy = y - lo;
					mag = (d < 0) ? 64'(-d) : 64'(d);
					prod = mag * 64'(dy);
					q = prod / 64'(w);
					r.correction = 32'(left + ((d < 0) ? -longint'(q) : longint'(q)));
					return r;
				end
			end
			n_no_segment++;
			r.status = ST_NO_SEGMENT;
			return r;
		endfunction

		function void note_item(logic cmd, logic [CHAN_W-1:0] ch, logic [SLOT_W-1:0] slot,
			logic [WORD_W-1:0] word, logic [WORD_W-1:0] pos);
			corr_result_t r;
			if (cmd == CMD_WRITE) begin
				n_writes++;
				if (ch < NCH && slot < NBP) begin
					table_words[ch*NBP+slot] = word;
					loaded[ch] = 1'b1;
				end
				r.correction = '0;
				r.status = ST_OK;
			end else begin
				n_queries++;
				r = interpolate_correction(ch, pos);
			end
			expected_results.push_back(r);
		endfunction

		function void check_result(logic [WORD_W-1:0] corr, logic [STATUS_W-1:0] st);
			corr_result_t e;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing pending: correction %h status %0d",
					$time, corr, st);
				return;
			end
			e = expected_results.pop_front();
			if (corr !== e.correction) begin
				errors++;
				$display("%0t: correction mismatch: expected %h, actual %h",
					$time, e.correction, corr);
			end
			if (st !== e.status) begin
				errors++;
				$display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status, st);
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n   = 1'b0;
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [PADDR_W-1:0]   paddr    = '0;
	logic [PDATA_W-1:0]   pwdata   = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// channel[7:0], slot[10:8], word_value[42:11], position[74:43], zero[79:75]
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 s_tuser  = 1'b0;  // cmd[0]
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [WORD_W-1:0]    m_tdata;          // correction[31:0]
	logic [STATUS_W-1:0]  m_tuser;          // status[1:0]

	interp_scoreboard         sb;
	logic signed [WORD_W-1:0] bp_setting [NUM_REGS];
	logic [5:0]               written_mask [NCH];
	bit                       is_full [NCH];
	int                       full_chans [$];
	int                       counted = 0;
	int                       settings_used = 0;
	bit                       source_gaps = 1'b1;
	bit                       sink_gaps = 1'b1;
	int unsigned              cycle_count = 0;

	per_channel_linear_interp_correction u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding",
				$time, cycle_count, sb.pending());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: check each transfer, then stall at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
		m_tready <= !(sink_gaps && $urandom_range(0, 99) < 29);
	end

	task automatic send_item(input logic cmd, input logic [CHAN_W-1:0] ch,
		input logic [SLOT_W-1:0] slot, input logic [WORD_W-1:0] word,
		input logic [WORD_W-1:0] pos);
		logic [S_TDATA_W-1:0] payload;
		payload = '0;
		payload[CHAN_LSB +: CHAN_W] = ch;
		payload[SLOT_LSB +: SLOT_W] = slot;
		payload[WORD_LSB +: WORD_W] = word;
		payload[POS_LSB +: WORD_W]  = pos;
		while (source_gaps && $urandom_range(0, 99) < 29) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= payload;
		s_tuser  <= cmd;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_item(cmd, ch, slot, word, pos);
		if (cmd == CMD_WRITE && slot >= NBP) return;
		counted++;
		if (cmd == CMD_WRITE) begin
			written_mask[ch] = written_mask[ch] | (6'd1 << slot);
			if (written_mask[ch] == ALL_SLOTS && !is_full[ch]) begin
				is_full[ch] = 1'b1;
				full_chans.push_back(ch);
			end
		end
	endtask

	task automatic write_word(input int ch, input int slot, input logic [WORD_W-1:0] word);
		send_item(CMD_WRITE, CHAN_W'(ch), SLOT_W'(slot), word, $urandom());
	endtask

	task automatic query(input int ch, input logic [WORD_W-1:0] pos);
		send_item(CMD_QUERY, CHAN_W'(ch), SLOT_W'($urandom_range(0, 7)), $urandom(), pos);
	endtask

	function automatic logic [WORD_W-1:0] extreme_word();
		case ($urandom_range(0, 3))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	// write the first n slots of a shuffled slot order
	task automatic write_slots(input int ch, input int n, input bit extremes);
		int order [NBP];
		int j, t;
		for (int k = 0; k < NBP; k++) order[k] = k;
		for (int k = NBP - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			t = order[k];
			order[k] = order[j];
			order[j] = t;
		end
		for (int k = 0; k < n; k++)
			write_word(ch, order[k], extremes ? extreme_word() : $urandom());
	endtask

	function automatic int pick_query_channel();
		int c;
		if ($urandom_range(0, 9) == 0) begin
			for (int tries = 0; tries < 20; tries++) begin
				c = $urandom_range(0, NCH - 1);
				if (written_mask[c] == '0) return c;
			end
		end
		return full_chans[$urandom_range(0, full_chans.size() - 1)];
	endfunction

	function automatic int pick_fresh_channel();
		int c;
		for (int tries = 0; tries < 20; tries++) begin
			c = $urandom_range(0, NCH - 1);
			if (written_mask[c] == '0) return c;
		end
		return -1;
	endfunction

	function automatic logic [WORD_W-1:0] pick_position();
		int r, i;
		longint lo, hi;
		logic [63:0] r64;
		r = $urandom_range(0, 99);
		if (r < 25)
			return bp_setting[$urandom_range(0, NBP - 1)] + 32'($urandom_range(0, 2)) - 32'd1;
		if (r < 70) begin
			i = $urandom_range(1, NBP - 1);
			lo = longint'(bp_setting[i-1]);
			hi = longint'(bp_setting[i]);
			if (lo <= hi) begin
				r64 = {$urandom(), $urandom()};
				return 32'(lo + longint'(r64 % 64'(hi - lo + 1)));
			end
			return $urandom();
		end
		if (r < 85) return $urandom();
		return extreme_word();
	endfunction

	task automatic apb_write(input int idx, input logic [PDATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(idx * 4);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_breakpoint(idx, val);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input bp_shape_t shape);
		logic signed [WORD_W-1:0] v [NUM_REGS];
		logic signed [WORD_W-1:0] t;
		bit wide, order_up, order_down;
		wide = (shape == BP_FULL_SPAN || shape == BP_DESCENDING || shape == BP_WIDE);
		order_up = (shape != BP_UNSORTED && shape != BP_DESCENDING);
		order_down = (shape == BP_DESCENDING);
		for (int i = 0; i < NUM_REGS; i++)
			v[i] = wide ? $urandom() : $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
		for (int i = 0; i < NUM_REGS - 1; i++)
			for (int j = 0; j < NUM_REGS - 1 - i; j++)
				if ((order_up && v[j] > v[j+1]) || (order_down && v[j] < v[j+1])) begin
					t = v[j];
					v[j] = v[j+1];
					v[j+1] = t;
				end
		if (shape == BP_FULL_SPAN) begin
			v[0] = 32'h8000_0000;
			v[NUM_REGS-1] = 32'h7fff_ffff;
		end
		if (shape == BP_REPEATED) begin
			v[1] = v[0];
			v[3] = v[2];
			v[4] = v[2];
		end
		for (int i = 0; i < NUM_REGS; i++) begin
			apb_write(i, v[i]);
			bp_setting[i] = v[i];
		end
		settings_used++;
	endtask

	// drop valid so the last item is not taken twice, then wait for its results
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic random_phase(input int budget);
		int target, r, c;
		target = counted + budget;
		while (counted < target) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				write_slots($urandom_range(0, NCH - 1), NBP, $urandom_range(0, 3) == 0);
			end else if (r < 20) begin
				write_word(full_chans[$urandom_range(0, full_chans.size() - 1)],
					$urandom_range(0, NBP - 1), $urandom());
			end else if (r < 24) begin
				// slot past the table: dropped by the block
				write_word($urandom_range(0, NCH - 1), $urandom_range(NBP, 7), $urandom());
			end else if (r < 27) begin
				c = pick_fresh_channel();
				if (c >= 0) write_slots(c, $urandom_range(1, NBP - 1), 1'b0);
			end else begin
				query(pick_query_channel(), pick_position());
			end
		end
	endtask

	initial begin
		bp_shape_t shapes [$];
		sb = new();
		foreach (bp_setting[i]) bp_setting[i] = '0;
		foreach (written_mask[i]) begin
			written_mask[i] = '0;
			is_full[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset breakpoints are all zero: every segment has zero width
		query(7, $urandom());
		write_word(NCH - 1, 6, 32'hffff_ffff);
		write_word(NCH - 1, 7, 32'h0000_0000);
		query(NCH - 1, 32'h0000_0000);
		write_word(0, 0, 32'h8000_0000);
		write_word(0, 1, 32'h7fff_ffff);
		write_word(0, 2, 32'h0000_0000);
		write_word(0, 3, 32'hffff_ffff);
		write_word(0, 4, 32'h7fff_ffff);
		write_word(0, 5, 32'h8000_0000);
		query(0, 32'h0000_0000);
		query(0, 32'hffff_ffff);
		query(0, 32'h0000_0001);
		query(0, 32'h8000_0000);
		query(0, 32'h7fff_ffff);
		write_word(NCH - 1, 5, 32'h8000_0000);
		write_word(NCH - 1, 4, 32'h7fff_ffff);
		write_word(NCH - 1, 3, 32'h8000_0000);
		write_word(NCH - 1, 2, 32'h7fff_ffff);
		write_word(NCH - 1, 1, 32'h8000_0000);
		write_word(NCH - 1, 0, 32'h7fff_ffff);
		query(NCH - 1, 32'h5555_5555);

		shapes = '{BP_NARROW, BP_FULL_SPAN, BP_REPEATED, BP_UNSORTED, BP_DESCENDING, BP_WIDE};
		foreach (shapes[i]) begin
			wait_drained();
			configure(shapes[i]);
			// first setting runs with both sides streaming flat out
			source_gaps = (i != 0);
			sink_gaps = (i != 0);
			random_phase(PHASE_ITEMS);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d writes and %0d queries over %0d breakpoint settings.",
			sb.n_writes, sb.n_queries, settings_used + 1);
		$display("Queries: %0d interpolated, %0d clamped, %0d zero-width, %0d unloaded.",
			sb.n_interp, sb.n_clamped, sb.n_zero_width, sb.n_unloaded);
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/plic_pkg.sv
hdl/per_channel_linear_interp_correction.sv
test/tb_per_channel_linear_interp_correction.sv
